/* sv/peu_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// peu_pkg
// shared types, constants and saturating fixed point helpers of the
// particle euler update block
// ----------------------------------------------------------------------------
package peu_pkg;

    localparam int DEF_MAX_PARTICLES = 64;
    localparam int DATA_W            = 32;
    localparam int DT_W              = 31;
    localparam int SLOT_W            = 6;
    localparam int CMD_W             = 2;
    localparam int REG_IDX_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND = 2'd0,
        CMD_APPEAR = 2'd1,
        CMD_TICK   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    localparam logic [REG_IDX_W-1:0] REG_ACCEL_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_ACCEL_Z = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_MUL,
        S_ADD,
        S_END
    } t_state;

    typedef struct packed {
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
        logic signed [DATA_W-1:0] vx;
        logic signed [DATA_W-1:0] vy;
        logic signed [DATA_W-1:0] vz;
    } t_kin;

    typedef struct packed {
        logic signed [DATA_W-1:0] energy;
        logic signed [DATA_W-1:0] size;
        logic signed [DATA_W-1:0] size_rate;
        logic signed [DATA_W-1:0] green;
        logic signed [DATA_W-1:0] green_rate;
        logic signed [DATA_W-1:0] alpha;
        logic signed [DATA_W-1:0] alpha_rate;
    } t_app;

    typedef struct packed {
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] pos_x;
        logic signed [DATA_W-1:0] pos_y;
        logic signed [DATA_W-1:0] pos_z;
        logic signed [DATA_W-1:0] size;
        logic signed [DATA_W-1:0] green;
        logic signed [DATA_W-1:0] alpha;
    } t_res;

    // x + floor(prod / 2^16), saturated
    function automatic logic signed [DATA_W-1:0] sat_step(
        input logic signed [DATA_W-1:0]   x,
        input logic signed [2*DATA_W-1:0] prod
    );
        logic signed [47:0] q;
        logic signed [48:0] s;
        q = prod[63:16];
        s = {{17{x[31]}}, x} + {q[47], q};
        if (s > 49'sd2147483647) begin
            sat_step = 32'sh7fffffff;
        end else if (s < -49'sd2147483648) begin
            sat_step = 32'sh80000000;
        end else begin
            sat_step = s[31:0];
        end
    endfunction

    // energy - dt, one bit wider so that it cannot overflow; not saturated here
    function automatic logic signed [DATA_W:0] energy_diff(
        input logic signed [DATA_W-1:0] e,
        input logic [DT_W-1:0]          dt
    );
        energy_diff = {e[31], e} - {2'b00, dt};
    endfunction

endpackage

`default_nettype wire

/* sv/peu_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// peu_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module peu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* sv/peu_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// peu_step
// two stage euler step: registered products, then add and saturate
// ----------------------------------------------------------------------------
module peu_step import peu_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_load,
    input  wire t_kin                     i_kin,
    input  wire t_app                     i_app,
    input  wire logic [DT_W-1:0]          i_dt,
    input  wire logic signed [DATA_W-1:0] i_acc_x,
    input  wire logic signed [DATA_W-1:0] i_acc_y,
    input  wire logic signed [DATA_W-1:0] i_acc_z,
    output t_kin                          o_kin,
    output t_app                          o_app,
    output logic                          o_dead
);

    logic signed [DATA_W-1:0]   dts;
    logic signed [2*DATA_W-1:0] r_p [9];
    t_kin                       r_kin;
    t_app                       r_app;
    logic [DT_W-1:0]            r_dt;
    logic signed [DATA_W:0]     ediff;

    assign dts = {1'b0, i_dt};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kin  <= i_kin;
            r_app  <= i_app;
            r_dt   <= i_dt;
            r_p[0] <= i_kin.vx * dts;
            r_p[1] <= i_kin.vy * dts;
            r_p[2] <= i_kin.vz * dts;
            r_p[3] <= i_acc_x * dts;
            r_p[4] <= i_acc_y * dts;
            r_p[5] <= i_acc_z * dts;
            r_p[6] <= i_app.size_rate * dts;
            r_p[7] <= i_app.green_rate * dts;
            r_p[8] <= i_app.alpha_rate * dts;
        end
    end

    always_comb begin
        ediff = energy_diff(r_app.energy, r_dt);
        o_kin.px = sat_step(r_kin.px, r_p[0]);
        o_kin.py = sat_step(r_kin.py, r_p[1]);
        o_kin.pz = sat_step(r_kin.pz, r_p[2]);
        o_kin.vx = sat_step(r_kin.vx, r_p[3]);
        o_kin.vy = sat_step(r_kin.vy, r_p[4]);
        o_kin.vz = sat_step(r_kin.vz, r_p[5]);
        o_app = r_app;
        if (ediff < -33'sd2147483648) begin
            o_app.energy = 32'sh80000000;
        end else begin
            o_app.energy = ediff[31:0];
        end
        o_app.size  = sat_step(r_app.size, r_p[6]);
        o_app.green = sat_step(r_app.green, r_p[7]);
        o_app.alpha = sat_step(r_app.alpha, r_p[8]);
        o_dead = (ediff <= 33'sd0);
    end

endmodule

`default_nettype wire

/* sv/particle_euler_update_compact_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// particle_euler_update_compact_core
// particle store with compacting euler update, signed q16.16
//
// channel  direction  handshake                  payload
// in       input      i_in_valid / o_in_ready    command, dt, operands a..g
// out      output     o_out_valid / i_out_ready  slot, position, size, green,
//                                                alpha, none_alive, last
// cfg      input      i_cfg_valid / o_cfg_ready  register index, data
//
// append, appearance and clear complete in the accept cycle.
// a tick visits the particles one at a time, each through ram read, multiply,
// and add and write back, before the next is read from the single ram read port.
// each dead particle adds one visit for its replacement.
// a stalled output holds the walk in the add stage; no clearing pass.
// reset is synchronous and clears the count, the state and the accel regs.
// ----------------------------------------------------------------------------
module particle_euler_update_compact_core import peu_pkg::*; #(
    parameter int MAX_PARTICLES = DEF_MAX_PARTICLES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [CMD_W-1:0]            i_command,
    input  wire logic [DT_W-1:0]             i_elapsed_time,
    input  wire logic signed [DATA_W-1:0]    i_operand_a,
    input  wire logic signed [DATA_W-1:0]    i_operand_b,
    input  wire logic signed [DATA_W-1:0]    i_operand_c,
    input  wire logic signed [DATA_W-1:0]    i_operand_d,
    input  wire logic signed [DATA_W-1:0]    i_operand_e,
    input  wire logic signed [DATA_W-1:0]    i_operand_f,
    input  wire logic signed [DATA_W-1:0]    i_operand_g,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [SLOT_W-1:0]                o_slot,
    output logic signed [DATA_W-1:0]         o_out_pos_x,
    output logic signed [DATA_W-1:0]         o_out_pos_y,
    output logic signed [DATA_W-1:0]         o_out_pos_z,
    output logic signed [DATA_W-1:0]         o_out_size,
    output logic signed [DATA_W-1:0]         o_out_green,
    output logic signed [DATA_W-1:0]         o_out_alpha,
    output logic                             o_none_alive,
    output logic                             o_last,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [REG_IDX_W-1:0]        i_cfg_index,
    input  wire logic signed [DATA_W-1:0]    i_cfg_data
);

    localparam int AW    = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PARTICLES);

    t_state                   r_state, n_state;
    logic [CNT_W-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]         r_i, n_i;
    logic [CNT_W-1:0]         r_src, n_src;
    logic [DT_W-1:0]          r_dt, n_dt;
    logic signed [DATA_W-1:0] r_acc_x, r_acc_y, r_acc_z;
    logic                     r_pend_valid, n_pend_valid;
    t_res                     r_pend, n_pend;
    logic                     r_out_valid, n_out_valid;
    t_res                     r_out, n_out;
    logic                     r_out_none, n_out_none;
    logic                     r_out_last, n_out_last;

    logic                     kin_we, app_we;
    logic [AW-1:0]            kin_waddr, app_waddr;
    t_kin                     kin_wdata, kin_rdata, step_kin;
    t_app                     app_wdata, app_rdata, step_app;
    logic                     step_dead;
    logic                     out_free;
    logic                     advance;
    logic                     in_acc;
    logic [CNT_W-1:0]         cnt_dec;
    t_res                     res_new;

    peu_ram #(.WIDTH($bits(t_kin)), .DEPTH(MAX_PARTICLES), .AW(AW)) u_kin_ram (
        .i_clk   (i_clk),
        .i_we    (kin_we),
        .i_waddr (kin_waddr),
        .i_wdata (kin_wdata),
        .i_raddr (r_src[AW-1:0]),
        .o_rdata (kin_rdata)
    );

    peu_ram #(.WIDTH($bits(t_app)), .DEPTH(MAX_PARTICLES), .AW(AW)) u_app_ram (
        .i_clk   (i_clk),
        .i_we    (app_we),
        .i_waddr (app_waddr),
        .i_wdata (app_wdata),
        .i_raddr (r_src[AW-1:0]),
        .o_rdata (app_rdata)
    );

    peu_step u_step (
        .i_clk   (i_clk),
        .i_load  (r_state == S_MUL),
        .i_kin   (kin_rdata),
        .i_app   (app_rdata),
        .i_dt    (r_dt),
        .i_acc_x (r_acc_x),
        .i_acc_y (r_acc_y),
        .i_acc_z (r_acc_z),
        .o_kin   (step_kin),
        .o_app   (step_app),
        .o_dead  (step_dead)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign cnt_dec     = r_cnt - CNT_W'(1);

    always_comb begin
        res_new       = '0;
        res_new.slot  = SLOT_W'(r_i);
        res_new.pos_x = step_kin.px;
        res_new.pos_y = step_kin.py;
        res_new.pos_z = step_kin.pz;
        res_new.size  = step_app.size;
        res_new.green = step_app.green;
        res_new.alpha = step_app.alpha;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_i          = r_i;
        n_src        = r_src;
        n_dt         = r_dt;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;
        n_out_none   = r_out_none;
        n_out_last   = r_out_last;
        kin_we       = 1'b0;
        app_we       = 1'b0;
        kin_waddr    = r_i[AW-1:0];
        app_waddr    = r_i[AW-1:0];
        kin_wdata    = step_kin;
        app_wdata    = step_app;
        advance      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (t_cmd'(i_command))
                        CMD_APPEND: begin
                            if (r_cnt < CNT_MAX) begin
                                kin_we    = 1'b1;
                                kin_waddr = r_cnt[AW-1:0];
                                kin_wdata = '{i_operand_a, i_operand_b, i_operand_c,
                                              i_operand_d, i_operand_e, i_operand_f};
                                n_cnt     = r_cnt + CNT_W'(1);
                            end
                        end
                        CMD_APPEAR: begin
                            if (r_cnt != '0) begin
                                app_we    = 1'b1;
                                app_waddr = cnt_dec[AW-1:0];
                                app_wdata = '{i_operand_a, i_operand_b, i_operand_c,
                                              i_operand_d, i_operand_e, i_operand_f,
                                              i_operand_g};
                            end
                        end
                        CMD_TICK: begin
                            n_i          = '0;
                            n_src        = '0;
                            n_dt         = i_elapsed_time;
                            n_pend_valid = 1'b0;
                            n_state      = (r_cnt == '0) ? S_END : S_RD;
                        end
                        CMD_CLEAR: begin
                            n_cnt = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_RD: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                if (step_dead || !r_pend_valid || out_free) begin
                    advance = 1'b1;
                    kin_we  = 1'b1;
                    app_we  = 1'b1;
                    if (step_dead) begin
                        n_cnt   = cnt_dec;
                        n_src   = cnt_dec;
                        n_state = (r_i < cnt_dec) ? S_RD : S_END;
                    end else begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out       = r_pend;
                            n_out_none  = 1'b0;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend       = res_new;
                        n_i          = r_i + CNT_W'(1);
                        n_src        = r_i + CNT_W'(1);
                        n_state      = (r_i + CNT_W'(1) < r_cnt) ? S_RD : S_END;
                    end
                end
            end
            S_END: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_last   = 1'b1;
                    n_out_none   = !r_pend_valid;
                    n_out        = r_pend_valid ? r_pend : '0;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt        <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_z      <= '0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_ACCEL_X: r_acc_x <= i_cfg_data;
                    REG_ACCEL_Y: r_acc_y <= i_cfg_data;
                    REG_ACCEL_Z: r_acc_z <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i        <= n_i;
        r_src      <= n_src;
        r_dt       <= n_dt;
        r_pend     <= n_pend;
        r_out      <= n_out;
        r_out_none <= n_out_none;
        r_out_last <= n_out_last;
    end

    assign o_out_valid  = r_out_valid;
    assign o_slot       = r_out.slot;
    assign o_out_pos_x  = r_out.pos_x;
    assign o_out_pos_y  = r_out.pos_y;
    assign o_out_pos_z  = r_out.pos_z;
    assign o_out_size   = r_out.size;
    assign o_out_green  = r_out.green;
    assign o_out_alpha  = r_out.alpha;
    assign o_none_alive = r_out_none;
    assign o_last       = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("live count above capacity");

    a_none_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_none_alive |-> o_last && (o_slot == '0))
        else $error("empty tick item not final or slot nonzero");

    a_dead_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ADD && advance && step_dead |=> r_cnt == $past(cnt_dec))
        else $error("dead particle did not shrink count");

    a_pend_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !r_pend_valid)
        else $error("pending item left over after tick");

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// particle euler update core: directed and random command streams with a
// bit exact predictor of the particle store, bursty input and a stalling
// output side, checked item by item in order
// ----------------------------------------------------------------------------
module testbench;
    import peu_pkg::*;

    localparam int NPART      = 64;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        t_cmd               cmd;
        logic [DT_W-1:0]    dt;
        logic [6:0][31:0]   op;
    } t_cmd_item;

    typedef struct {
        logic [SLOT_W-1:0]  slot;
        logic [31:0]        px, py, pz, sz, gr, al;
        logic               none;
        logic               last;
    } t_survivor;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_in_valid;
    logic                     o_in_ready;
    logic [CMD_W-1:0]         i_command;
    logic [DT_W-1:0]          i_elapsed_time;
    logic signed [DATA_W-1:0] i_operand_a, i_operand_b, i_operand_c, i_operand_d;
    logic signed [DATA_W-1:0] i_operand_e, i_operand_f, i_operand_g;
    logic                     o_out_valid;
    logic                     i_out_ready;
    logic [SLOT_W-1:0]        o_slot;
    logic signed [DATA_W-1:0] o_out_pos_x, o_out_pos_y, o_out_pos_z;
    logic signed [DATA_W-1:0] o_out_size, o_out_green, o_out_alpha;
    logic                     o_none_alive;
    logic                     o_last;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [REG_IDX_W-1:0]     i_cfg_index;
    logic signed [DATA_W-1:0] i_cfg_data;

    particle_euler_update_compact_core u_top (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_ready, .i_command, .i_elapsed_time,
        .i_operand_a, .i_operand_b, .i_operand_c, .i_operand_d, .i_operand_e,
        .i_operand_f, .i_operand_g, .o_out_valid, .i_out_ready, .o_slot,
        .o_out_pos_x, .o_out_pos_y, .o_out_pos_z, .o_out_size, .o_out_green,
        .o_out_alpha, .o_none_alive, .o_last, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data
    );

    // predictor state
    int    acc_x, acc_y, acc_z;
    int    pos_mem [0:3*NPART-1];
    int    vel_mem [0:3*NPART-1];
    int    eng_mem [0:NPART-1];
    int    siz_mem [0:NPART-1];
    int    sizr_mem[0:NPART-1];
    int    grn_mem [0:NPART-1];
    int    grnr_mem[0:NPART-1];
    int    alp_mem [0:NPART-1];
    int    alpr_mem[0:NPART-1];
    bit    has_look[0:NPART-1];
    int    live_n;
    int    n_sent;

    t_cmd_item pending_cmds[$];
    t_survivor expected_survivors[$];

    int    fails;
    int    cycles;
    logic  in_fire;
    int    burst_left, gap_left, stall_left, calm_left;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'h7fffffff;
        if (v < -64'sd2147483648) return 32'h80000000;
        return int'(v);
    endfunction

    function automatic int euler_add(int x, int rate, longint dt);
        longint p;
        p = longint'(rate) * dt;
        return sat32(longint'(x) + (p >>> 16));
    endfunction

    task automatic move_particle(int dst, int src);
        for (int k = 0; k < 3; k++) begin
            pos_mem[dst*3+k] = pos_mem[src*3+k];
            vel_mem[dst*3+k] = vel_mem[src*3+k];
        end
        eng_mem[dst]  = eng_mem[src];
        siz_mem[dst]  = siz_mem[src];
        sizr_mem[dst] = sizr_mem[src];
        grn_mem[dst]  = grn_mem[src];
        grnr_mem[dst] = grnr_mem[src];
        alp_mem[dst]  = alp_mem[src];
        alpr_mem[dst] = alpr_mem[src];
        has_look[dst] = has_look[src];
    endtask

    task automatic advance_particle(int i, longint dt);
        int acc[3];
        acc[0] = acc_x;
        acc[1] = acc_y;
        acc[2] = acc_z;
        for (int k = 0; k < 3; k++) begin
            pos_mem[i*3+k] = euler_add(pos_mem[i*3+k], vel_mem[i*3+k], dt);
            vel_mem[i*3+k] = euler_add(vel_mem[i*3+k], acc[k], dt);
        end
        eng_mem[i] = sat32(longint'(eng_mem[i]) - dt);
        siz_mem[i] = euler_add(siz_mem[i], sizr_mem[i], dt);
        alp_mem[i] = euler_add(alp_mem[i], alpr_mem[i], dt);
        grn_mem[i] = euler_add(grn_mem[i], grnr_mem[i], dt);
    endtask

    // queue an item and work out the survivors it produces
    task automatic issue_cmd(t_cmd c, logic [DT_W-1:0] dt, logic [6:0][31:0] op);
        t_cmd_item it;
        t_survivor s;
        longint    dtl;
        int        i;
        it.cmd = c;
        it.dt  = dt;
        it.op  = op;
        pending_cmds.push_back(it);
        n_sent++;
        dtl = longint'({33'd0, dt});
        case (c)
            CMD_APPEND: begin
                if (live_n < NPART) begin
                    for (int k = 0; k < 3; k++) begin
                        pos_mem[live_n*3+k] = op[k];
                        vel_mem[live_n*3+k] = op[3+k];
                    end
                    has_look[live_n] = 0;
                    live_n++;
                end
            end
            CMD_APPEAR: begin
                if (live_n > 0) begin
                    eng_mem[live_n-1]  = op[0];
                    siz_mem[live_n-1]  = op[1];
                    sizr_mem[live_n-1] = op[2];
                    grn_mem[live_n-1]  = op[3];
                    grnr_mem[live_n-1] = op[4];
                    alp_mem[live_n-1]  = op[5];
                    alpr_mem[live_n-1] = op[6];
                    has_look[live_n-1] = 1;
                end
            end
            CMD_CLEAR: live_n = 0;
            default: begin
                i = 0;
                while (i < live_n) begin
                    advance_particle(i, dtl);
                    if (eng_mem[i] <= 0) begin
                        live_n--;
                        move_particle(i, live_n);
                    end else begin
                        i++;
                    end
                end
                if (live_n == 0) begin
                    s = '{default: '0};
                    s.none = 1;
                    s.last = 1;
                    expected_survivors.push_back(s);
                end
                for (int j = 0; j < live_n; j++) begin
                    s.slot = j[5:0];
                    s.px   = pos_mem[j*3];
                    s.py   = pos_mem[j*3+1];
                    s.pz   = pos_mem[j*3+2];
                    s.sz   = siz_mem[j];
                    s.gr   = grn_mem[j];
                    s.al   = alp_mem[j];
                    s.none = 0;
                    s.last = (j == live_n - 1);
                    expected_survivors.push_back(s);
                end
            end
        endcase
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return $urandom_range(0, 200 << 16) - (100 << 16);
        endcase
    endfunction

    function automatic logic [6:0][31:0] rand_ops();
        logic [6:0][31:0] op;
        for (int k = 0; k < 7; k++) op[k] = rand_word();
        return op;
    endfunction

    function automatic logic [6:0][31:0] rand_look();
        logic [6:0][31:0] op;
        op = rand_ops();
        if ($urandom_range(0, 7) != 0) op[0] = $urandom_range(1, 6 << 16);
        return op;
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        if ($urandom_range(0, 15) == 0) return DT_W'($urandom);
        return DT_W'($urandom_range(0, 32'h18000));
    endfunction

    // the newest particle may still lack its appearance; give it one
    task automatic finish_look();
        if (live_n > 0 && !has_look[live_n-1]) issue_cmd(CMD_APPEAR, '0, rand_look());
    endtask

    // never tick over a particle without appearance
    task automatic issue_tick(logic [DT_W-1:0] dt);
        finish_look();
        issue_cmd(CMD_TICK, dt, rand_ops());
    endtask

    task automatic issue_particle();
        finish_look();
        issue_cmd(CMD_APPEND, '0, rand_ops());
        issue_cmd(CMD_APPEAR, '0, rand_look());
    endtask

    task automatic wait_drained();
        forever begin
            @(posedge i_clk);
            if (pending_cmds.size() == 0 && expected_survivors.size() == 0 && !i_in_valid)
                break;
        end
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, int val);
        @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        forever begin
            @(posedge i_clk);
            if (o_cfg_ready) break;
        end
        @(negedge i_clk);
        i_cfg_valid = 0;
        case (idx)
            REG_ACCEL_X: acc_x = val;
            REG_ACCEL_Y: acc_y = val;
            REG_ACCEL_Z: acc_z = val;
            default: ;
        endcase
    endtask

    task automatic check_field(string name, longint e, longint a);
        if (e != a) begin
            fails++;
            $display("%0t mismatch %s expected %h actual %h", $realtime, name, e, a);
        end
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_fire)) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_in_valid <= 0;
            end else if (pending_cmds.size() > 0) begin
                t_cmd_item it;
                it = pending_cmds.pop_front();
                i_in_valid     <= 1;
                i_command      <= it.cmd;
                i_elapsed_time <= it.dt;
                i_operand_a    <= it.op[0];
                i_operand_b    <= it.op[1];
                i_operand_c    <= it.op[2];
                i_operand_d    <= it.op[3];
                i_operand_e    <= it.op[4];
                i_operand_f    <= it.op[5];
                i_operand_g    <= it.op[6];
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 12);
                    gap_left   <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_in_valid <= 0;
            end
        end
    end

    // output stall pattern
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 0;
        end else begin
            i_out_ready <= 1;
            if (calm_left > 0) begin
                calm_left <= calm_left - 1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall_left <= $urandom_range(1, 5);
                calm_left  <= $urandom_range(0, 1) ? $urandom_range(20, 120) : 0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        in_fire <= i_in_valid && o_in_ready;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_survivors.size() == 0) begin
                fails++;
                $display("%0t unexpected item slot %0d", $realtime, o_slot);
            end else begin
                t_survivor e;
                e = expected_survivors.pop_front();
                check_field("slot", e.slot, o_slot);
                check_field("pos_x", e.px, $unsigned(o_out_pos_x));
                check_field("pos_y", e.py, $unsigned(o_out_pos_y));
                check_field("pos_z", e.pz, $unsigned(o_out_pos_z));
                check_field("size", e.sz, $unsigned(o_out_size));
                check_field("green", e.gr, $unsigned(o_out_green));
                check_field("alpha", e.al, $unsigned(o_out_alpha));
                check_field("none_alive", e.none, o_none_alive);
                check_field("last", e.last, o_last);
            end
        end
    end

    initial begin
        logic [6:0][31:0] op;
        int               start_n;
        fails = 0; cycles = 0; live_n = 0; in_fire = 0; n_sent = 0;
        burst_left = 0; gap_left = 0; stall_left = 0; calm_left = 0;
        acc_x = 0; acc_y = 0; acc_z = 0;
        i_rst_n = 0; i_in_valid = 0; i_out_ready = 0;
        i_command = '0; i_elapsed_time = '0;
        i_operand_a = '0; i_operand_b = '0; i_operand_c = '0; i_operand_d = '0;
        i_operand_e = '0; i_operand_f = '0; i_operand_g = '0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1;

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_ACCEL_X, 32'h7fffffff);
                    write_reg(REG_ACCEL_Y, 32'h80000000);
                    write_reg(REG_ACCEL_Z, 0);
                end
                2: begin
                    write_reg(REG_ACCEL_X, 32'h80000000);
                    write_reg(REG_ACCEL_Y, 32'h7fffffff);
                    write_reg(REG_ACCEL_Z, 32'h7fffffff);
                end
                3: begin
                    write_reg(REG_ACCEL_X, $urandom_range(0, 4 << 16) - (2 << 16));
                    write_reg(REG_ACCEL_Y, $urandom_range(0, 4 << 16) - (2 << 16));
                    write_reg(REG_ACCEL_Z, 32'h80000000);
                end
                default: begin
                    write_reg(REG_ACCEL_X, $urandom);
                    write_reg(REG_ACCEL_Y, $urandom);
                    write_reg(REG_ACCEL_Z, $urandom);
                end
            endcase
            // writes to the unused index are ignored
            write_reg(REG_IDX_W'(REG_ACCEL_Z + 1), $urandom);

            if (ph == 0) begin
                issue_tick(DT_W'($urandom));
                issue_cmd(CMD_APPEAR, '0, rand_ops());
                for (int k = 0; k < 7; k++) op[k] = 32'h7fffffff;
                issue_cmd(CMD_APPEND, '0, op);
                issue_cmd(CMD_APPEAR, '0, op);
                for (int k = 0; k < 7; k++) op[k] = 32'h80000000;
                issue_cmd(CMD_APPEND, '0, op);
                op[0] = 32'h7fffffff;
                issue_cmd(CMD_APPEAR, '0, op);
                issue_tick(31'h10000);
                issue_tick(31'h7fffffff);
                op = rand_ops();
                op[0] = 0;
                issue_cmd(CMD_APPEND, '0, rand_ops());
                issue_cmd(CMD_APPEAR, '0, op);
                op[0] = 32'h80000000;
                issue_cmd(CMD_APPEND, '0, rand_ops());
                issue_cmd(CMD_APPEAR, '0, op);
                issue_particle();
                issue_tick(0);
                issue_tick(31'h8000);
                issue_cmd(CMD_CLEAR, '0, rand_ops());
                issue_tick(31'h1);
                issue_cmd(CMD_CLEAR, '0, rand_ops());
            end else begin
                // fill to capacity once, then try one append too many
                if (ph == 2) begin
                    while (live_n < NPART) issue_particle();
                    issue_cmd(CMD_APPEND, '0, rand_ops());
                    issue_cmd(CMD_APPEAR, '0, rand_look());
                    issue_tick(31'h100);
                end
                start_n = n_sent;
                while (n_sent - start_n < 10) begin
                    case ($urandom_range(0, 11))
                        0, 1, 2, 3: begin
                            issue_particle();
                        end
                        4, 5, 6, 9: begin
                            issue_tick(rand_dt());
                        end
                        7: begin
                            finish_look();
                            issue_cmd(t_cmd'($urandom_range(0, 1)), DT_W'($urandom),
                                      rand_look());
                        end
                        8: begin
                            if ($urandom_range(0, 3) == 0)
                                issue_cmd(CMD_CLEAR, DT_W'($urandom), rand_ops());
                        end
                        default: begin
                            issue_tick(DT_W'($urandom));
                        end
                    endcase
                end
                // the last particle must carry its appearance for later ticks
                finish_look();
            end
            wait_drained();
        end

        repeat (40) @(negedge i_clk);
        if (fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
